// ===== hw/rtl/grs_pkg.sv =====
// ----------------------------------------------------------------------------
// Gas reading smoother package
// Shared widths, reset values, register indexes, status codes and the
// divider status record.
// ----------------------------------------------------------------------------
package grs_pkg;

	localparam int DEF_WINDOW_DEPTH = 8;

	localparam int RAW_W      = 32;
	localparam int VAL_W      = 16;
	localparam int FRAC_W     = 4;
	localparam int FILT_W     = 20;
	localparam int LVL_W      = 3;
	localparam int STAT_W     = 2;
	localparam int WEIGHT_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [VAL_W-1:0]    RST_LOW_LIMIT  = 16'd400;
	localparam logic [VAL_W-1:0]    RST_HIGH_LIMIT = 16'd5000;
	localparam logic [VAL_W-1:0]    RST_GRADE_ONE  = 16'd800;
	localparam logic [VAL_W-1:0]    RST_GRADE_TWO  = 16'd1200;
	localparam logic [VAL_W-1:0]    RST_GRADE_THR  = 16'd2000;
	localparam logic [VAL_W-1:0]    RST_GRADE_FOUR = 16'd3000;
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT     = 8'd77;

	localparam logic [LVL_W-1:0] LEVEL_NONE  = 3'd0;
	localparam logic [LVL_W-1:0] LEVEL_ONE   = 3'd1;
	localparam logic [LVL_W-1:0] LEVEL_TWO   = 3'd2;
	localparam logic [LVL_W-1:0] LEVEL_THREE = 3'd3;
	localparam logic [LVL_W-1:0] LEVEL_FOUR  = 3'd4;
	localparam logic [LVL_W-1:0] LEVEL_FIVE  = 3'd5;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_READ_FAIL = 2'd1,
		STAT_RANGE     = 2'd2
	} grs_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOW_LIMIT   = 3'd0,
		CFG_HIGH_LIMIT  = 3'd1,
		CFG_GRADE_ONE   = 3'd2,
		CFG_GRADE_TWO   = 3'd3,
		CFG_GRADE_THREE = 3'd4,
		CFG_GRADE_FOUR  = 3'd5,
		CFG_WEIGHT      = 3'd6
	} grs_cfg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} grs_div_stat_t;

endpackage

// ===== hw/rtl/grs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module grs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/grs_div.sv =====
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle; done pulses for one cycle when the
// quotient is ready.
// ----------------------------------------------------------------------------
module grs_div #(
	parameter int NUM_W = 23,
	parameter int DEN_W = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUM_W-1:0]       dividend,
	input  logic [DEN_W-1:0]       divisor,
	output grs_pkg::grs_div_stat_t stat,
	output logic [NUM_W-1:0]       quotient
);

	import grs_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             fits;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = num_q;

	ap_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider finished without running");

	ap_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0) && (cnt_q <= CW'(NUM_W)))
		else $error("divider count out of bounds");

endmodule

// ===== hw/rtl/gas_reading_smoother_top.sv =====
// ----------------------------------------------------------------------------
// Gas reading smoother
// Windowed mean of accepted readings followed by an exponential average
// and a five-level air grade.
// ----------------------------------------------------------------------------
// Accepted reading: the request passes through READ, DIV, MUL, BLEND and DONE;
// in DIV the serial divider produces one quotient bit per cycle.
// Rejected reading: the request goes straight from IDLE to DONE.
// One reading is processed at a time; the state returns to IDLE, where the next
// request is taken, on the same edge that registers the result.
// Reset restores the register defaults and empties the window at once.
// ----------------------------------------------------------------------------
module gas_reading_smoother_top #(
	parameter int WINDOW_DEPTH = grs_pkg::DEF_WINDOW_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            reading_valid,
	output logic                            reading_stall,
	input  logic [grs_pkg::RAW_W-1:0]       raw_ppm,
	input  logic                            read_failed,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [grs_pkg::STAT_W-1:0]      status,
	output logic [grs_pkg::FILT_W-1:0]      filtered_sixteenths,
	output logic [grs_pkg::LVL_W-1:0]       quality_level,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [grs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [grs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import grs_pkg::*;

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int SUM_W = VAL_W + $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int NUM_W = SUM_W + FRAC_W;
	localparam int MUL_W = WEIGHT_W + FILT_W;
	localparam int ACC_W = MUL_W + 2;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_BLEND = 6'b010000,
		ST_DONE  = 6'b100000
	} grs_state_t;

	grs_state_t state_q;

	logic [VAL_W-1:0]    low_limit_q;
	logic [VAL_W-1:0]    high_limit_q;
	logic [VAL_W-1:0]    grade_one_q;
	logic [VAL_W-1:0]    grade_two_q;
	logic [VAL_W-1:0]    grade_three_q;
	logic [VAL_W-1:0]    grade_four_q;
	logic [WEIGHT_W-1:0] weight_q;

	logic [AW-1:0]       slot_q;
	logic                wrapped_q;
	logic [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [FILT_W-1:0]   smoothed_q;
	logic [LVL_W-1:0]    grade_q;

	grs_status_t         status_q;
	logic                ok_q;
	logic [VAL_W-1:0]    value_q;
	logic [FILT_W-1:0]   avg_q;
	logic [MUL_W-1:0]    mul_q;

	logic                result_valid_q;
	logic [STAT_W-1:0]   status_out_q;
	logic [FILT_W-1:0]   filt_out_q;
	logic [LVL_W-1:0]    level_out_q;

	logic                accept;
	logic                out_free;
	logic [VAL_W-1:0]    ram_rd_data;
	logic [VAL_W-1:0]    old_val;
	logic [SUM_W-1:0]    sum_new;
	logic [CNT_W-1:0]    cnt_new;
	logic [NUM_W-1:0]    dividend;
	logic                div_start;
	grs_div_stat_t       div_stat;
	logic [NUM_W-1:0]    quotient;
	logic [ACC_W-1:0]    acc;
	logic [LVL_W-1:0]    grade_new;
	logic                in_range;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_limit_q   <= RST_LOW_LIMIT;
			high_limit_q  <= RST_HIGH_LIMIT;
			grade_one_q   <= RST_GRADE_ONE;
			grade_two_q   <= RST_GRADE_TWO;
			grade_three_q <= RST_GRADE_THR;
			grade_four_q  <= RST_GRADE_FOUR;
			weight_q      <= RST_WEIGHT;
		end else if (cfg_valid) begin
			case (grs_cfg_idx_t'(cfg_index))
				CFG_LOW_LIMIT:   low_limit_q   <= cfg_data;
				CFG_HIGH_LIMIT:  high_limit_q  <= cfg_data;
				CFG_GRADE_ONE:   grade_one_q   <= cfg_data;
				CFG_GRADE_TWO:   grade_two_q   <= cfg_data;
				CFG_GRADE_THREE: grade_three_q <= cfg_data;
				CFG_GRADE_FOUR:  grade_four_q  <= cfg_data;
				CFG_WEIGHT:      weight_q      <= cfg_data[WEIGHT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign reading_stall = (state_q != ST_IDLE);
	assign accept        = reading_valid && (state_q == ST_IDLE);
	assign out_free      = !result_valid_q || !result_stall;
	assign in_range      = (raw_ppm >= {{(RAW_W-VAL_W){1'b0}}, low_limit_q})
		&& (raw_ppm <= {{(RAW_W-VAL_W){1'b0}}, high_limit_q});

	// The slot about to be written holds data only after the first full pass.
	assign old_val   = wrapped_q ? ram_rd_data : '0;
	assign sum_new   = sum_q - SUM_W'(old_val) + SUM_W'(value_q);
	assign cnt_new   = cnt_q - CNT_W'(old_val != '0) + CNT_W'(value_q != '0);
	assign dividend  = {sum_new, {FRAC_W{1'b0}}} + NUM_W'(cnt_new >> 1);
	assign div_start = (state_q == ST_READ);

	grs_ram #(
		.WIDTH(VAL_W),
		.DEPTH(WINDOW_DEPTH)
	) u_window_ram (
		.clk    (clk),
		.wr_en  (state_q == ST_READ),
		.wr_addr(slot_q),
		.wr_data(value_q),
		.rd_en  (accept),
		.rd_addr(slot_q),
		.rd_data(ram_rd_data)
	);

	grs_div #(
		.NUM_W(NUM_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (cnt_new),
		.stat    (div_stat),
		.quotient(quotient)
	);

	assign acc = ACC_W'(mul_q)
		+ ACC_W'(9'd256 - {1'b0, weight_q}) * ACC_W'(smoothed_q)
		+ ACC_W'(128);

	always_comb begin
		if (smoothed_q <= {grade_one_q, {FRAC_W{1'b0}}}) begin
			grade_new = LEVEL_ONE;
		end else if (smoothed_q <= {grade_two_q, {FRAC_W{1'b0}}}) begin
			grade_new = LEVEL_TWO;
		end else if (smoothed_q <= {grade_three_q, {FRAC_W{1'b0}}}) begin
			grade_new = LEVEL_THREE;
		end else if (smoothed_q <= {grade_four_q, {FRAC_W{1'b0}}}) begin
			grade_new = LEVEL_FOUR;
		end else begin
			grade_new = LEVEL_FIVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			slot_q         <= '0;
			wrapped_q      <= 1'b0;
			sum_q          <= '0;
			cnt_q          <= '0;
			smoothed_q     <= '0;
			grade_q        <= LEVEL_NONE;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (read_failed || !in_range) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					sum_q <= sum_new;
					cnt_q <= cnt_new;
					if (slot_q == AW'(WINDOW_DEPTH - 1)) begin
						slot_q    <= '0;
						wrapped_q <= 1'b1;
					end else begin
						slot_q <= slot_q + AW'(1);
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					if (smoothed_q == '0) begin
						smoothed_q <= avg_q;
					end else begin
						smoothed_q <= acc[FILT_W+7:8];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						if (ok_q) begin
							grade_q <= grade_new;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= raw_ppm[VAL_W-1:0];
			if (read_failed) begin
				status_q <= STAT_READ_FAIL;
				ok_q     <= 1'b0;
			end else if (!in_range) begin
				status_q <= STAT_RANGE;
				ok_q     <= 1'b0;
			end else begin
				status_q <= STAT_OK;
				ok_q     <= 1'b1;
			end
		end
		if (state_q == ST_DIV && div_stat.done) begin
			avg_q <= (cnt_q == '0) ? '0 : quotient[FILT_W-1:0];
		end
		if (state_q == ST_MUL) begin
			mul_q <= weight_q * avg_q;
		end
		if (state_q == ST_DONE && out_free) begin
			status_out_q <= status_q;
			filt_out_q   <= smoothed_q;
			level_out_q  <= ok_q ? grade_new : grade_q;
		end
	end

	assign result_valid        = result_valid_q;
	assign status              = status_out_q;
	assign filtered_sixteenths = filt_out_q;
	assign quality_level       = level_out_q;

	ap_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result registered outside the completion step");

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(WINDOW_DEPTH))
		else $error("filled count exceeds the window depth");

	ap_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (sum_q == '0))
		else $error("window sum nonzero with no filled entries");

	ap_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the wait step");

	ap_grade_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free && ok_q) |=> (grade_q != LEVEL_NONE))
		else $error("accepted reading left no grade");

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Gas reading smoother testbench
// Drives raw gas readings through the smoother under many register settings and
// random handshake pressure. Each result is compared field by field with a typed
// row's value or a cycle-free model of window mean, exponential average, grading.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import grs_pkg::*;

	localparam int DEPTH           = DEF_WINDOW_DEPTH;
	localparam int PHASES          = 12;
	localparam int FIXED_PHASES    = 6;
	localparam int READINGS_PHASE  = 38;
	localparam int LONG_HOLD       = 200;
	localparam int IDLE_LIMIT      = 3000;
	localparam int END_QUIET       = 64;
	localparam int REPORT_LIMIT    = 10;
	localparam int DIRECTED_ROWS   = 21;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	typedef struct packed {
		grs_status_t           st;
		logic [FILT_W-1:0]     filt;
		logic [LVL_W-1:0]      lvl;
	} readout_t;

	typedef struct packed {
		logic [RAW_W-1:0]      raw;
		logic                  failed;
		logic                  typed;
		readout_t              want;
	} directed_row_t;

	typedef struct packed {
		logic [VAL_W-1:0]      low;
		logic [VAL_W-1:0]      high;
		logic [VAL_W-1:0]      c1;
		logic [VAL_W-1:0]      c2;
		logic [VAL_W-1:0]      c3;
		logic [VAL_W-1:0]      c4;
		logic [WEIGHT_W-1:0]   weight;
	} settings_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   reading_valid = 1'b0;
	logic                   reading_stall;
	logic [RAW_W-1:0]       raw_ppm = '0;
	logic                   read_failed = 1'b0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [STAT_W-1:0]      status;
	logic [FILT_W-1:0]      filtered_sixteenths;
	logic [LVL_W-1:0]       quality_level;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Model copy of the registers and the filter state.
	logic [VAL_W-1:0]       lim_low, lim_high;
	logic [VAL_W-1:0]       grade_ceil [1:4];
	logic [WEIGHT_W-1:0]    weight;
	logic [VAL_W-1:0]       win [DEPTH];
	int unsigned            win_slot, win_sum, win_filled;
	logic [FILT_W-1:0]      ewma;
	logic [LVL_W-1:0]       grade;

	readout_t               readouts_due [$];
	directed_row_t          forced_row;
	logic                   forced_pending = 1'b0;

	int  mismatch_count = 0, results_seen = 0, settings_applied = 0;
	int  n_ok = 0, n_failed = 0, n_range = 0;
	int  burst_left = 0;
	bit  tx_bursty = 1'b0;
	int  rx_mode = 0;
	int  hold_token = 0, hold_served = 0, hold_left = 0;
	int  idle_cycles = 0;
	logic [31:0] pattern_bits = '0;
	int  pattern_pos = 0;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'd1000,       1'b1, 1'b1, '{STAT_READ_FAIL, 20'd0,    LEVEL_NONE}},
		'{32'd0,          1'b0, 1'b1, '{STAT_RANGE,     20'd0,    LEVEL_NONE}},
		'{32'hFFFF_FFFF,  1'b0, 1'b1, '{STAT_RANGE,     20'd0,    LEVEL_NONE}},
		'{32'd399,        1'b0, 1'b1, '{STAT_RANGE,     20'd0,    LEVEL_NONE}},
		'{32'd5001,       1'b0, 1'b1, '{STAT_RANGE,     20'd0,    LEVEL_NONE}},
		'{32'h0001_0190,  1'b0, 1'b1, '{STAT_RANGE,     20'd0,    LEVEL_NONE}},
		'{32'd400,        1'b0, 1'b1, '{STAT_OK,        20'd6400, LEVEL_ONE}},
		'{32'd5000,       1'b0, 1'b0, '0},
		'{32'd5000,       1'b1, 1'b0, '0},
		'{32'd6000,       1'b0, 1'b0, '0},
		'{32'd800,        1'b0, 1'b0, '0},
		'{32'd1200,       1'b0, 1'b0, '0},
		'{32'd2000,       1'b0, 1'b0, '0},
		'{32'd3000,       1'b0, 1'b0, '0},
		'{32'd4000,       1'b0, 1'b0, '0},
		'{32'd4999,       1'b0, 1'b0, '0},
		'{32'd401,        1'b0, 1'b0, '0},
		'{32'd1000,       1'b0, 1'b0, '0},
		'{32'h8000_1388,  1'b0, 1'b0, '0},
		'{32'd4500,       1'b0, 1'b0, '0},
		'{32'hFFFF_FFFF,  1'b1, 1'b0, '0}
	};

	settings_t fixed_settings [FIXED_PHASES] = '{
		'{16'd0,     16'd65535, 16'd0,     16'd1,     16'd4095,  16'd65535, 8'd255},
		'{16'd1000,  16'd900,   16'd800,   16'd1200,  16'd2000,  16'd3000,  8'd1},
		'{16'd0,     16'd3000,  16'd3000,  16'd100,   16'd2000,  16'd50,    8'd0},
		'{16'd0,     16'd65535, 16'd0,     16'd0,     16'd0,     16'd0,     8'd128},
		'{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 8'd200},
		'{RST_LOW_LIMIT, RST_HIGH_LIMIT, RST_GRADE_ONE, RST_GRADE_TWO,
		  RST_GRADE_THR, RST_GRADE_FOUR, RST_WEIGHT}
	};

	gas_reading_smoother_top #(.WINDOW_DEPTH(DEPTH)) DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.reading_valid       (reading_valid),
		.reading_stall       (reading_stall),
		.raw_ppm             (raw_ppm),
		.read_failed         (read_failed),
		.result_valid        (result_valid),
		.result_stall        (result_stall),
		.status              (status),
		.filtered_sixteenths (filtered_sixteenths),
		.quality_level       (quality_level),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [LVL_W-1:0] level_of(input logic [FILT_W-1:0] v);
		if (v <= {grade_ceil[1], 4'b0000}) return LEVEL_ONE;
		if (v <= {grade_ceil[2], 4'b0000}) return LEVEL_TWO;
		if (v <= {grade_ceil[3], 4'b0000}) return LEVEL_THREE;
		if (v <= {grade_ceil[4], 4'b0000}) return LEVEL_FOUR;
		return LEVEL_FIVE;
	endfunction

	function automatic readout_t smooth_reading(input logic [RAW_W-1:0] raw,
			input logic failed);
		readout_t          r;
		logic [VAL_W-1:0]  value, old;
		longint unsigned   avg, acc;
		if (failed) begin
			r.st = STAT_READ_FAIL;
		end else if (raw < lim_low || raw > lim_high) begin
			r.st = STAT_RANGE;
		end else begin
			r.st = STAT_OK;
			value = raw[VAL_W-1:0];
			old = win[win_slot];
			win_sum = win_sum - old + value;
			if (old != 0) win_filled--;
			if (value != 0) win_filled++;
			win[win_slot] = value;
			win_slot = (win_slot + 1) % DEPTH;
			if (win_filled != 0)
				avg = (64'(win_sum) * 16 + win_filled / 2) / win_filled;
			else
				avg = 64'(value) * 16;
			if (ewma == 0) begin
				ewma = avg[FILT_W-1:0];
			end else begin
				acc = 64'(weight) * avg + (64'd256 - 64'(weight)) * 64'(ewma) + 64'd128;
				ewma = acc[FILT_W+7:8];
			end
			grade = level_of(ewma);
		end
		r.filt = ewma;
		r.lvl = grade;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input readout_t want);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] %s: expected status %0d filtered %0d level %0d, got %0d %0d %0d",
				$realtime, what, want.st, want.filt, want.lvl,
				status, filtered_sixteenths, quality_level);
	endtask

	// Prediction on accepted requests, then comparison of accepted results.
	always @(posedge clk) begin
		readout_t r, w;
		if (arst_n && reading_valid && !reading_stall) begin
			r = smooth_reading(raw_ppm, read_failed);
			case (r.st)
				STAT_OK:        n_ok++;
				STAT_READ_FAIL: n_failed++;
				default:        n_range++;
			endcase
			if (forced_pending && forced_row.typed) r = forced_row.want;
			forced_pending = 1'b0;
			readouts_due.push_back(r);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LOW_LIMIT:   lim_low = cfg_data;
				CFG_HIGH_LIMIT:  lim_high = cfg_data;
				CFG_GRADE_ONE:   grade_ceil[1] = cfg_data;
				CFG_GRADE_TWO:   grade_ceil[2] = cfg_data;
				CFG_GRADE_THREE: grade_ceil[3] = cfg_data;
				CFG_GRADE_FOUR:  grade_ceil[4] = cfg_data;
				CFG_WEIGHT:      weight = cfg_data[WEIGHT_W-1:0];
				default:         ;
			endcase
		end
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (readouts_due.size() == 0) begin
				report_mismatch("result with no request pending", '0);
			end else begin
				w = readouts_due.pop_front();
				if (status !== w.st || filtered_sixteenths !== w.filt ||
						quality_level !== w.lvl)
					report_mismatch($sformatf("mismatch at result %0d", results_seen), w);
			end
		end
	end

	// Output side: a long hold on request, otherwise no stall or a random stall pattern.
	always @(negedge clk) begin
		if (hold_served != hold_token) begin
			hold_served = hold_token;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (rx_mode == 0) begin
			result_stall <= 1'b0;
		end else begin
			if (pattern_pos == 0)
				pattern_bits = (rx_mode == 1) ? ($urandom & $urandom) : ($urandom | $urandom);
			result_stall <= pattern_bits[pattern_pos];
			pattern_pos = (pattern_pos + 1) % 32;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (reading_valid && !reading_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: %0d cycles without any transfer", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_reading(input logic [RAW_W-1:0] raw, input logic failed);
		int gap;
		gap = 0;
		if (tx_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 35);
			end
			burst_left--;
		end
		if (gap > 0) begin
			reading_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		reading_valid <= 1'b1;
		raw_ppm <= raw;
		read_failed <= failed;
		@(posedge clk);
		while (reading_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apply_settings(input settings_t s);
		write_reg(CFG_LOW_LIMIT, s.low);
		write_reg(CFG_HIGH_LIMIT, s.high);
		write_reg(CFG_GRADE_ONE, s.c1);
		write_reg(CFG_GRADE_TWO, s.c2);
		write_reg(CFG_GRADE_THREE, s.c3);
		write_reg(CFG_GRADE_FOUR, s.c4);
		write_reg(CFG_WEIGHT, {8'($urandom), s.weight});
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic wait_drained();
		reading_valid <= 1'b0;
		while (readouts_due.size() != 0) @(negedge clk);
	endtask

	function automatic logic [RAW_W-1:0] pick_raw();
		int k;
		k = $urandom_range(0, 99);
		if (k < 8) return $urandom;
		if (k < 14) return '0;
		if (k < 20) return 32'(lim_low) - 1;
		if (k < 26) return 32'(lim_high) + 1;
		if (k < 30) return 32'(lim_low);
		if (k < 34) return 32'(lim_high);
		if (lim_low <= lim_high) return $urandom_range(lim_high, lim_low);
		return $urandom_range(65535, 0);
	endfunction

	function automatic settings_t random_settings();
		settings_t s;
		int unsigned top;
		s.low = 16'($urandom_range(0, 3000));
		top = s.low + $urandom_range(0, 60000);
		s.high = (top > 65535) ? 16'd65535 : top[VAL_W-1:0];
		s.c1 = 16'($urandom_range(0, 20000));
		s.c2 = 16'(s.c1 + $urandom_range(0, 15000));
		s.c3 = 16'(s.c2 + $urandom_range(0, 15000));
		s.c4 = 16'(s.c3 + $urandom_range(0, 15000));
		s.weight = 8'($urandom_range(0, 255));
		return s;
	endfunction

	initial begin
		lim_low = RST_LOW_LIMIT;
		lim_high = RST_HIGH_LIMIT;
		grade_ceil[1] = RST_GRADE_ONE;
		grade_ceil[2] = RST_GRADE_TWO;
		grade_ceil[3] = RST_GRADE_THR;
		grade_ceil[4] = RST_GRADE_FOUR;
		weight = RST_WEIGHT;
		for (int i = 0; i < DEPTH; i++) win[i] = '0;
		win_slot = 0;
		win_sum = 0;
		win_filled = 0;
		ewma = '0;
		grade = LEVEL_NONE;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			forced_row = directed_rows[i];
			forced_pending = 1'b1;
			send_reading(directed_rows[i].raw, directed_rows[i].failed);
		end
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				write_reg(CFG_UNUSED_IDX, 16'($urandom));
			end
			apply_settings((p < FIXED_PHASES) ? fixed_settings[p] : random_settings());
			tx_bursty = (p % 3 != 0);
			rx_mode = p % 3;
			if (p == 3) begin
				tx_bursty = 1'b0;
				hold_token++;
			end
			for (int n = 0; n < READINGS_PHASE; n++)
				send_reading(pick_raw(), $urandom_range(0, 9) == 0);
			wait_drained();
		end

		repeat (END_QUIET) @(posedge clk);
		if (readouts_due.size() != 0) begin
			$display("%0d results never arrived", readouts_due.size());
			mismatch_count += readouts_due.size();
		end
		$display("covered %0d readings: %0d accepted, %0d failed reads, %0d out of range",
			n_ok + n_failed + n_range, n_ok, n_failed, n_range);
		$display("%0d register settings, %0d results compared, %0d bad",
			settings_applied, results_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
